### design/elevator_call_dispatcher_assert.svh
// Assertion macros shared by the elevator call dispatcher modules.
`ifndef ELEVATOR_CALL_DISPATCHER_ASSERT_SVH
`define ELEVATOR_CALL_DISPATCHER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define ECD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define ECD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ecd_pkg.sv
// Types, codes and constants shared by the elevator call dispatcher modules.
package ecd_pkg;

  // Number of floors served; floor numbers are carried in FLOOR_W bits.
  localparam int FLOOR_COUNT = 10;
  localparam int FLOOR_W     = 4;
  localparam int OP_W        = 3;
  localparam int WAY_W       = 2;

  typedef logic [FLOOR_COUNT-1:0] map_t;
  typedef logic [FLOOR_W-1:0]     floor_t;
  typedef logic [OP_W-1:0]        op_t;
  typedef logic [WAY_W-1:0]       way_t;

  // Highest floor and the floor count at a width that fits a floor compare.
  localparam floor_t               TOP_FLOOR    = FLOOR_W'(FLOOR_COUNT - 1);
  localparam logic [FLOOR_W:0]     FLOOR_LIMIT  = (FLOOR_W + 1)'(FLOOR_COUNT);

  // Event codes.
  localparam op_t OP_HALL   = 3'd0;
  localparam op_t OP_CAR    = 3'd1;
  localparam op_t OP_FLOOR  = 3'd2;
  localparam op_t OP_QUERY  = 3'd3;
  localparam op_t OP_SERVED = 3'd4;

  // Trip direction codes.
  localparam way_t WAY_IDLE = 2'd0;
  localparam way_t WAY_UP   = 2'd1;
  localparam way_t WAY_DOWN = 2'd2;

  // One input beat.
  typedef struct packed {
    op_t    opcode;
    floor_t call_floor;
    logic   call_going_up;
  } ecd_item_t;

  // One result beat.
  typedef struct packed {
    floor_t dest_floor;
    logic   dest_valid;
    way_t   travel_dir;
    floor_t car_floor;
    logic   at_destination;
  } ecd_res_t;

endpackage

### design/ecd_find.sv
// Priority encoders giving the lowest and highest pending floor of a call map.
module ecd_find (
  input  ecd_pkg::map_t   map,
  output ecd_pkg::floor_t lowest,
  output ecd_pkg::floor_t highest,
  output logic            any
);

  // Lowest set bit: scan downward so the lowest set bit is written last.
  always_comb begin
    lowest = '0;
    for (int i = ecd_pkg::FLOOR_COUNT - 1; i >= 0; i--) begin
      if (map[i]) begin
        lowest = ecd_pkg::FLOOR_W'(i);
      end
    end
  end

  // Highest set bit: scan upward so the highest set bit is written last.
  always_comb begin
    highest = '0;
    for (int i = 0; i < ecd_pkg::FLOOR_COUNT; i++) begin
      if (map[i]) begin
        highest = ecd_pkg::FLOOR_W'(i);
      end
    end
  end

  assign any = |map;

endmodule

### design/ecd_state.sv
// Car state registers and the per-event update and destination logic.
`include "elevator_call_dispatcher_assert.svh"

module ecd_state (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  ecd_pkg::ecd_item_t item,
  output ecd_pkg::ecd_res_t  res
);

  ecd_pkg::floor_t floor_now_r, floor_now_nxt;
  ecd_pkg::way_t   trip_way_r, trip_way_nxt;
  ecd_pkg::map_t   this_r, this_nxt;
  ecd_pkg::map_t   next_r, next_nxt;

  logic            idle;
  logic            travelling;
  logic            in_range;
  logic            ahead;
  ecd_pkg::way_t   call_way;
  ecd_pkg::map_t   call_bit;
  ecd_pkg::map_t   here_bit;
  logic            new_trip;
  ecd_pkg::map_t   pick_map;
  ecd_pkg::floor_t pick_lo;
  ecd_pkg::floor_t pick_hi;
  logic            pick_any;
  ecd_pkg::way_t   pick_way;

  // Decode of the beat against the current state.
  assign idle       = (trip_way_r == ecd_pkg::WAY_IDLE);
  assign travelling = (trip_way_r == ecd_pkg::WAY_UP) || (trip_way_r == ecd_pkg::WAY_DOWN);
  assign in_range   = ({1'b0, item.call_floor} < ecd_pkg::FLOOR_LIMIT);
  assign call_way   = item.call_going_up ? ecd_pkg::WAY_UP : ecd_pkg::WAY_DOWN;
  assign call_bit   = ecd_pkg::map_t'(1) << item.call_floor;
  assign here_bit   = ecd_pkg::map_t'(1) << floor_now_r;
  assign ahead      = ((item.call_floor > floor_now_r) && (trip_way_r == ecd_pkg::WAY_UP)) ||
                      ((item.call_floor < floor_now_r) && (trip_way_r == ecd_pkg::WAY_DOWN));

  // A query on an exhausted trip promotes the deferred calls.
  assign new_trip = travelling && (this_r == '0);
  assign pick_map = new_trip ? next_r : this_r;

  ecd_find u_find (
    .map     (pick_map),
    .lowest  (pick_lo),
    .highest (pick_hi),
    .any     (pick_any)
  );

  // Direction after a query: kept while the trip has calls, else chosen anew.
  always_comb begin
    if (travelling && !new_trip) begin
      pick_way = trip_way_r;
    end else if (!pick_any) begin
      pick_way = ecd_pkg::WAY_IDLE;
    end else if (pick_lo > floor_now_r) begin
      pick_way = ecd_pkg::WAY_UP;
    end else begin
      pick_way = ecd_pkg::WAY_DOWN;
    end
  end

  // Next state and the result of the beat.
  always_comb begin
    floor_now_nxt = floor_now_r;
    trip_way_nxt  = trip_way_r;
    this_nxt      = this_r;
    next_nxt      = next_r;
    res.dest_floor = '0;
    res.dest_valid = 1'b0;
    case (item.opcode)
      ecd_pkg::OP_HALL: begin
        if (in_range) begin
          if ((item.call_floor != floor_now_r) && (idle || (trip_way_r == call_way))) begin
            this_nxt = this_r | call_bit;
          end else begin
            next_nxt = next_r | call_bit;
          end
        end
      end
      ecd_pkg::OP_CAR: begin
        if (in_range && !(idle && (item.call_floor == floor_now_r))) begin
          if (ahead || idle) begin
            this_nxt = this_r | call_bit;
          end else begin
            next_nxt = next_r | call_bit;
          end
        end
      end
      ecd_pkg::OP_FLOOR: begin
        if ((trip_way_r == ecd_pkg::WAY_UP) && (floor_now_r < ecd_pkg::TOP_FLOOR)) begin
          floor_now_nxt = floor_now_r + ecd_pkg::FLOOR_W'(1);
        end else if ((trip_way_r == ecd_pkg::WAY_DOWN) && (floor_now_r != '0)) begin
          floor_now_nxt = floor_now_r - ecd_pkg::FLOOR_W'(1);
        end
      end
      ecd_pkg::OP_QUERY: begin
        if (new_trip) begin
          this_nxt = next_r;
          next_nxt = '0;
        end
        trip_way_nxt   = pick_way;
        res.dest_valid = pick_any;
        if (pick_any) begin
          res.dest_floor = (pick_way == ecd_pkg::WAY_UP) ? pick_lo : pick_hi;
        end
      end
      ecd_pkg::OP_SERVED: begin
        this_nxt = this_r & ~here_bit;
      end
      default: begin
      end
    endcase
    res.travel_dir     = trip_way_nxt;
    res.car_floor      = floor_now_nxt;
    res.at_destination = res.dest_valid && (res.dest_floor == floor_now_nxt);
  end

  // State registers advance only on an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_now_r <= '0;
      trip_way_r  <= ecd_pkg::WAY_IDLE;
      this_r      <= '0;
      next_r      <= '0;
    end else if (fire) begin
      floor_now_r <= floor_now_nxt;
      trip_way_r  <= trip_way_nxt;
      this_r      <= this_nxt;
      next_r      <= next_nxt;
    end
  end

  // The car never leaves the building.
  `ECD_ASSERT_IMP(a_floor_in_range, 1'b1, floor_now_r <= ecd_pkg::TOP_FLOOR, "car floor out of range")
  // A found destination always comes with a trip direction.
  `ECD_ASSERT_IMP(a_dest_has_way, fire && (item.opcode == ecd_pkg::OP_QUERY) && res.dest_valid, res.travel_dir != ecd_pkg::WAY_IDLE, "destination found while idle")
  // Promoting the deferred calls empties the deferred map.
  `ECD_ASSERT_NXT(a_promote_clears, fire && (item.opcode == ecd_pkg::OP_QUERY) && travelling && (this_r == '0), next_r == '0, "deferred map not cleared on new trip")

endmodule

### design/elevator_call_dispatcher.sv
// Top level of the elevator call dispatcher: input register, state logic, output register.
//
// Usage:
//   Input channel (in_valid, in_stall, in_opcode, in_call_floor, in_call_going_up)
//   carries one event per beat: hall call, car call, floor passed, query or served.
//   Result channel (out_valid, out_stall, out_dest_floor, out_dest_valid,
//   out_travel_dir, out_car_floor, out_at_destination) returns exactly one
//   beat per event, in order, with the car state after that event.
//   An accepted input beat goes into the input register, then through the update
//   logic into the output register. One event per cycle is sustained while the
//   receiver does not stall; the state update is a single pass of bit setting,
//   a floor step and a ten-bit priority encode.
//   When the receiver stalls, the result holds, the pending event waits in the
//   input register and in_stall rises only once both registers are full.
//   Synchronous active-low reset puts the car at floor 0, idle, with both call
//   maps clear, and empties both registers.
`include "elevator_call_dispatcher_assert.svh"

module elevator_call_dispatcher (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ecd_pkg::op_t         in_opcode,
  input  ecd_pkg::floor_t      in_call_floor,
  input  logic                 in_call_going_up,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ecd_pkg::floor_t      out_dest_floor,
  output logic                 out_dest_valid,
  output ecd_pkg::way_t        out_travel_dir,
  output ecd_pkg::floor_t      out_car_floor,
  output logic                 out_at_destination
);

  logic               item_valid_r, item_valid_nxt;
  ecd_pkg::ecd_item_t item_r;
  logic               res_valid_r, res_valid_nxt;
  ecd_pkg::ecd_res_t  res_r;
  ecd_pkg::ecd_res_t  res;
  logic               fire;

  // The held event moves on when the output register is free or being emptied.
  assign fire     = item_valid_r && (!res_valid_r || !out_stall);
  assign in_stall = item_valid_r && !fire;

  assign item_valid_nxt = in_stall ? item_valid_r : in_valid;
  assign res_valid_nxt  = fire ? 1'b1 : (res_valid_r && out_stall);

  ecd_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .res   (res)
  );

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r.opcode        <= in_opcode;
      item_r.call_floor    <= in_call_floor;
      item_r.call_going_up <= in_call_going_up;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid          = res_valid_r;
  assign out_dest_floor     = res_r.dest_floor;
  assign out_dest_valid     = res_r.dest_valid;
  assign out_travel_dir     = res_r.travel_dir;
  assign out_car_floor      = res_r.car_floor;
  assign out_at_destination = res_r.at_destination;

  // Arrival is only flagged for a real destination.
  `ECD_ASSERT_IMP(a_arrival_needs_dest, out_valid && out_at_destination, out_dest_valid, "arrival without destination")

endmodule

### sim/tb_elevator_call_dispatcher.sv
// Self-checking testbench for the elevator call dispatcher: directed table, then random events.
`timescale 1ns / 1ps

module tb_elevator_call_dispatcher;
  import ecd_pkg::*;

  // Opcodes the block must ignore.
  localparam op_t OP_SPARE5 = 3'd5;
  localparam op_t OP_SPARE7 = 3'd7;

  // Result of any non-query event with the car idle at the ground floor.
  localparam ecd_res_t QUIET_RES = '0;

  localparam int RANDOM_EVENTS = 800;
  localparam int DIR_ROWS      = 29;
  localparam int SQUEEZE_AT    = 150;
  localparam int SQUEEZE_LEN   = 80;

  // One row of the directed table; fixed_res selects the typed-in result.
  typedef struct packed {
    op_t      op;
    floor_t   flr;
    logic     up;
    logic     fixed_res;
    ecd_res_t res;
  } call_row_t;

  // Walk from reset through a full up trip, saturation at the top floor and a new trip down.
  call_row_t opening_calls [DIR_ROWS] = '{
    '{OP_QUERY,   4'd0,  1'b0, 1'b1, QUIET_RES},
    '{OP_FLOOR,   4'd0,  1'b0, 1'b1, QUIET_RES},
    '{OP_CAR,     4'd0,  1'b0, 1'b1, QUIET_RES},
    '{OP_HALL,    4'd15, 1'b1, 1'b1, QUIET_RES},
    '{OP_CAR,     4'd10, 1'b0, 1'b1, QUIET_RES},
    '{OP_SPARE5,  4'd3,  1'b1, 1'b1, QUIET_RES},
    '{OP_SPARE7,  4'd9,  1'b0, 1'b1, QUIET_RES},
    '{OP_SERVED,  4'd0,  1'b0, 1'b1, QUIET_RES},
    '{OP_HALL,    4'd9,  1'b1, 1'b1, QUIET_RES},
    '{OP_HALL,    4'd0,  1'b0, 1'b1, QUIET_RES},
    '{OP_QUERY,   4'd0,  1'b0, 1'b1, '{4'd9, 1'b1, WAY_UP, 4'd0, 1'b0}},
    '{OP_CAR,     4'd5,  1'b0, 1'b0, QUIET_RES},
    '{OP_FLOOR,   4'd0,  1'b0, 1'b0, QUIET_RES},
    '{OP_FLOOR,   4'd0,  1'b0, 1'b0, QUIET_RES},
    '{OP_FLOOR,   4'd0,  1'b0, 1'b0, QUIET_RES},
    '{OP_FLOOR,   4'd0,  1'b0, 1'b0, QUIET_RES},
    '{OP_FLOOR,   4'd0,  1'b0, 1'b0, QUIET_RES},
    '{OP_QUERY,   4'd0,  1'b0, 1'b0, QUIET_RES},
    '{OP_SERVED,  4'd0,  1'b0, 1'b0, QUIET_RES},
    '{OP_CAR,     4'd2,  1'b1, 1'b0, QUIET_RES},
    '{OP_HALL,    4'd7,  1'b0, 1'b0, QUIET_RES},
    '{OP_FLOOR,   4'd0,  1'b0, 1'b0, QUIET_RES},
    '{OP_FLOOR,   4'd0,  1'b0, 1'b0, QUIET_RES},
    '{OP_FLOOR,   4'd0,  1'b0, 1'b0, QUIET_RES},
    '{OP_FLOOR,   4'd0,  1'b0, 1'b0, QUIET_RES},
    '{OP_FLOOR,   4'd0,  1'b0, 1'b0, QUIET_RES},
    '{OP_QUERY,   4'd0,  1'b0, 1'b0, QUIET_RES},
    '{OP_SERVED,  4'd0,  1'b0, 1'b0, QUIET_RES},
    '{OP_QUERY,   4'd0,  1'b0, 1'b0, QUIET_RES}
  };

  logic   clk = 1'b0;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  op_t    in_opcode;
  floor_t in_call_floor;
  logic   in_call_going_up;
  logic   out_valid;
  logic   out_stall;
  floor_t out_dest_floor;
  logic   out_dest_valid;
  way_t   out_travel_dir;
  floor_t out_car_floor;
  logic   out_at_destination;

  // Car state as the testbench tracks it.
  floor_t car_at;
  way_t   trip;
  map_t   this_map;
  map_t   next_map;

  ecd_res_t due_results[$];
  int       err_cnt = 0;
  int       n_events;
  int       n_checked = 0;
  int       n_found = 0;
  bit       calm;
  bit       squeeze_req;
  bit       squeeze_done = 1'b0;
  int       hold_left = 0;

  elevator_call_dispatcher u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_call_floor      (in_call_floor),
    .in_call_going_up   (in_call_going_up),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_dest_floor     (out_dest_floor),
    .out_dest_valid     (out_dest_valid),
    .out_travel_dir     (out_travel_dir),
    .out_car_floor      (out_car_floor),
    .out_at_destination (out_at_destination)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int lowest_call(map_t m);
    for (int i = 0; i < FLOOR_COUNT; i++) begin
      if (m[i]) return i;
    end
    return -1;
  endfunction

  function automatic int highest_call(map_t m);
    for (int i = FLOOR_COUNT - 1; i >= 0; i--) begin
      if (m[i]) return i;
    end
    return -1;
  endfunction

  // Applies one event to the tracked car state and returns the result beat it causes.
  function automatic ecd_res_t dispatch_event(op_t op, floor_t cf, logic up);
    ecd_res_t r;
    way_t     call_way;
    logic     was_idle;
    logic     ahead;
    int       pick;
    r        = '0;
    call_way = up ? WAY_UP : WAY_DOWN;
    was_idle = (trip == WAY_IDLE);
    pick     = -1;
    case (op)
      OP_HALL: begin
        if (cf < FLOOR_COUNT) begin
          if (cf != car_at && (was_idle || trip == call_way)) this_map[cf] = 1'b1;
          else next_map[cf] = 1'b1;
        end
      end
      OP_CAR: begin
        // A car call at the car's floor while idle is dropped.
        if (cf < FLOOR_COUNT && !(was_idle && cf == car_at)) begin
          ahead = (cf > car_at && trip == WAY_UP) || (cf < car_at && trip == WAY_DOWN);
          if (ahead || (was_idle && cf != car_at)) this_map[cf] = 1'b1;
          else next_map[cf] = 1'b1;
        end
      end
      OP_FLOOR: begin
        if (trip == WAY_UP && car_at < TOP_FLOOR) car_at = car_at + 1'b1;
        else if (trip == WAY_DOWN && car_at != '0) car_at = car_at - 1'b1;
      end
      OP_QUERY: begin
        // An empty trip hands over to the deferred calls and goes idle.
        if (trip != WAY_IDLE && this_map == '0) begin
          this_map = next_map;
          next_map = '0;
          trip     = WAY_IDLE;
        end
        if (trip == WAY_IDLE) begin
          pick = lowest_call(this_map);
          if (pick >= 0) trip = (pick > car_at) ? WAY_UP : WAY_DOWN;
        end
        if (trip == WAY_UP) pick = lowest_call(this_map);
        else if (trip == WAY_DOWN) pick = highest_call(this_map);
        if (pick >= 0) begin
          r.dest_floor = floor_t'(pick);
          r.dest_valid = 1'b1;
        end
      end
      OP_SERVED: begin
        this_map[car_at] = 1'b0;
      end
      default: begin
      end
    endcase
    r.travel_dir     = trip;
    r.car_floor      = car_at;
    r.at_destination = r.dest_valid && (r.dest_floor == car_at);
    return r;
  endfunction

  // Offers one input beat, with an optional idle gap first, and returns once it is taken.
  task automatic offer_event(op_t op, floor_t flr, logic up);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_call_floor    <= flr;
    in_call_going_up <= up;
    do @(posedge clk); while (in_stall);
    n_events++;
  endtask

  // Result side: compare each taken beat, then choose the stall for the next cycle.
  always @(posedge clk) begin
    ecd_res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result beat with nothing outstanding");
          err_cnt++;
        end else begin
          want = due_results.pop_front();
          n_checked++;
          if (out_dest_valid) n_found++;
          if (out_dest_floor !== want.dest_floor) begin
            $error("dest_floor: expected %0d, got %0d", want.dest_floor, out_dest_floor);
            err_cnt++;
          end
          if (out_dest_valid !== want.dest_valid) begin
            $error("dest_valid: expected %0d, got %0d", want.dest_valid, out_dest_valid);
            err_cnt++;
          end
          if (out_travel_dir !== want.travel_dir) begin
            $error("travel_dir: expected %0d, got %0d", want.travel_dir, out_travel_dir);
            err_cnt++;
          end
          if (out_car_floor !== want.car_floor) begin
            $error("car_floor: expected %0d, got %0d", want.car_floor, out_car_floor);
            err_cnt++;
          end
          if (out_at_destination !== want.at_destination) begin
            $error("at_destination: expected %0d, got %0d",
                   want.at_destination, out_at_destination);
            err_cnt++;
          end
        end
      end
      // One long hold-off so the block fills up and pushes back on its input.
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold_left    = SQUEEZE_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 15);
      end
    end
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("tb_elevator_call_dispatcher: done, errors");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    call_row_t row;
    ecd_res_t  r;
    op_t       op;
    floor_t    flr;
    logic      up;
    int        sel;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_opcode        = OP_HALL;
    in_call_floor    = '0;
    in_call_going_up = 1'b0;
    car_at           = '0;
    trip             = WAY_IDLE;
    this_map         = '0;
    next_map         = '0;
    n_events         = 0;
    calm             = 1'b0;
    squeeze_req      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = opening_calls[i];
      offer_event(row.op, row.flr, row.up);
      r = dispatch_event(row.op, row.flr, row.up);
      due_results.push_back(row.fixed_res ? row.res : r);
    end

    // Random events, mostly well-formed calls, moves, queries and serves.
    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      calm = (i >= 300 && i < 450);
      if (i == SQUEEZE_AT) squeeze_req = 1'b1;
      sel = $urandom_range(99);
      if (sel < 25) op = OP_HALL;
      else if (sel < 50) op = OP_CAR;
      else if (sel < 70) op = OP_FLOOR;
      else if (sel < 85) op = OP_QUERY;
      else if (sel < 95) op = OP_SERVED;
      else op = op_t'($urandom_range(OP_SPARE7, OP_SPARE5));
      if ($urandom_range(99) < 8) flr = floor_t'($urandom_range(15, FLOOR_COUNT));
      else flr = floor_t'($urandom_range(FLOOR_COUNT - 1, 0));
      up = 1'($urandom_range(1));
      offer_event(op, flr, up);
      due_results.push_back(dispatch_event(op, flr, up));
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain, then give any stray beat time to show up.
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d events (%0d from the directed table), compared %0d result beats.",
             n_events, DIR_ROWS, n_checked);
    $display("%0d queries returned a destination; the output was held off once for %0d cycles.",
             n_found, SQUEEZE_LEN);
    if (err_cnt == 0) begin
      $display("tb_elevator_call_dispatcher: done, clean");
    end else begin
      $display("tb_elevator_call_dispatcher: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/ecd_pkg.sv
design/ecd_find.sv
design/ecd_state.sv
design/elevator_call_dispatcher.sv
sim/tb_elevator_call_dispatcher.sv
